// File: sv/tilt_and_heading_angles_unit_defines.svh
// Assertion helpers shared by the angle unit modules.
// Each macro expects clk and rst_n in scope.
`ifndef TILT_AND_HEADING_ANGLES_UNIT_DEFINES_SVH
`define TILT_AND_HEADING_ANGLES_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TAH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TAH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/tah_pkg.sv
package tah_pkg;

  localparam int SAMPLE_WIDTH   = 16;
  localparam int ROTATION_STEPS = 16;
  localparam int ATAN_TAB_LEN   = 24;
  localparam int ROT_STEPS      = (ROTATION_STEPS < ATAN_TAB_LEN) ? ROTATION_STEPS
                                                                  : ATAN_TAB_LEN;
  localparam int ROT_IDX_W      = $clog2(ATAN_TAB_LEN);

  // Square root of (y^2 + z^2) << 2*MAG_GUARD, one result bit per cell.
  localparam int MAG_GUARD = 8;
  localparam int SUM_W     = 2 * SAMPLE_WIDTH;
  localparam int SQ_N_W    = SUM_W + 2 * MAG_GUARD;
  localparam int SQ_R_W    = SQ_N_W / 2;
  localparam int SQ_REM_W  = SQ_R_W + 2;

  // Operands are scaled up until the larger magnitude reaches 2^NORM_EXP.
  localparam int NORM_EXP    = 40;
  localparam int MAG_W       = NORM_EXP + 1;
  localparam int DATA_W      = NORM_EXP + 4;
  localparam int NORM_STAGES = 7;
  localparam int SHIFT_W     = 6;

  localparam int ANG_FRAC      = 15;
  localparam int OUT_FRAC      = 7;
  localparam int ROUND_SHIFT   = ANG_FRAC - OUT_FRAC;
  localparam int ANG_W         = 25;
  localparam int DEG_HALF_TURN = 180;
  localparam logic signed [ANG_W-1:0] HALF_TURN_Z = ANG_W'(DEG_HALF_TURN * (2 ** ANG_FRAC));

  localparam int PITCH_W     = 15;
  localparam int HEAD_W      = 16;
  localparam int PITCH_MAX   = 11520;
  localparam int HEADING_MAX = 23040;

  // atan(2^-i) in degrees with 15 fraction bits.
  localparam int ATAN_TAB [ATAN_TAB_LEN] = '{
    1474560, 870484, 459940, 233473, 117189, 58653, 29333, 14667,
    7334, 3667, 1833, 917, 458, 229, 115, 57,
    29, 14, 7, 4, 2, 1, 0, 0
  };

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] ax;
    logic signed [SAMPLE_WIDTH-1:0] mx;
    logic signed [SAMPLE_WIDTH-1:0] my;
  } tah_side_t;

  // Round the accumulator to 1/128 degree (half up) and clamp to +-lim.
  function automatic logic signed [HEAD_W-1:0] round_sat(input logic signed [ANG_W-1:0] z,
                                                         input int lim);
    logic signed [ANG_W:0] t;
    logic signed [ANG_W:0] lim_s;
    t     = (ANG_W+1)'(z) + (ANG_W+1)'(2 ** (ROUND_SHIFT - 1));
    t     = t >>> ROUND_SHIFT;
    lim_s = (ANG_W+1)'(lim);
    if (t > lim_s) begin
      t = lim_s;
    end else if (t < -lim_s) begin
      t = -lim_s;
    end
    return t[HEAD_W-1:0];
  endfunction

endpackage

// File: sv/tah_sqrt_cell.sv
module tah_sqrt_cell
  import tah_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                vld_i,
  input  logic [SQ_N_W-1:0]   n_i,
  input  logic [SQ_REM_W-1:0] rem_i,
  input  logic [SQ_R_W-1:0]   q_i,
  input  tah_side_t           side_i,
  output logic                vld_o,
  output logic [SQ_N_W-1:0]   n_o,
  output logic [SQ_REM_W-1:0] rem_o,
  output logic [SQ_R_W-1:0]   q_o,
  output tah_side_t           side_o
);

  logic                vld_r;
  logic [SQ_N_W-1:0]   n_r,   n_nxt;
  logic [SQ_REM_W-1:0] rem_r, rem_nxt;
  logic [SQ_R_W-1:0]   q_r,   q_nxt;
  tah_side_t           side_r;
  logic [SQ_REM_W-1:0] rem_sh;
  logic [SQ_REM_W-1:0] trial;
  logic                take;

  // Restoring square root: bring down two radicand bits, try (4q + 1).
  always_comb begin
    rem_sh  = {rem_i[SQ_REM_W-3:0], n_i[SQ_N_W-1 -: 2]};
    trial   = {q_i, 2'b01};
    take    = (rem_sh >= trial);
    rem_nxt = take ? (rem_sh - trial) : rem_sh;
    q_nxt   = {q_i[SQ_R_W-2:0], take};
    n_nxt   = {n_i[SQ_N_W-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    n_r    <= n_nxt;
    rem_r  <= rem_nxt;
    q_r    <= q_nxt;
    side_r <= side_i;
  end

  assign vld_o  = vld_r;
  assign n_o    = n_r;
  assign rem_o  = rem_r;
  assign q_o    = q_r;
  assign side_o = side_r;

endmodule

// File: sv/tah_norm_cell.sv
module tah_norm_cell
  import tah_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [SHIFT_W-1:0]       sh_i,
  input  logic [SHIFT_W-1:0]       exp_i,
  input  logic                     vld_i,
  input  logic signed [DATA_W-1:0] x_i,
  input  logic signed [DATA_W-1:0] y_i,
  input  logic [MAG_W-1:0]         m_i,
  output logic                     vld_o,
  output logic signed [DATA_W-1:0] x_o,
  output logic signed [DATA_W-1:0] y_o,
  output logic [MAG_W-1:0]         m_o
);

  logic                     vld_r;
  logic signed [DATA_W-1:0] x_r, x_nxt;
  logic signed [DATA_W-1:0] y_r, y_nxt;
  logic [MAG_W-1:0]         m_r, m_nxt;
  logic [MAG_W-1:0]         lim;
  logic                     go;

  // Shift by sh_i only if the magnitude is below 2^exp_i before the shift.
  always_comb begin
    lim   = MAG_W'(1) << exp_i;
    go    = (m_i < lim);
    x_nxt = go ? (x_i <<< sh_i) : x_i;
    y_nxt = go ? (y_i <<< sh_i) : y_i;
    m_nxt = go ? (m_i << sh_i) : m_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    m_r <= m_nxt;
  end

  assign vld_o = vld_r;
  assign x_o   = x_r;
  assign y_o   = y_r;
  assign m_o   = m_r;

endmodule

// File: sv/tah_rot_cell.sv
module tah_rot_cell
  import tah_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [ROT_IDX_W-1:0]     idx_i,
  input  logic                     vld_i,
  input  logic signed [DATA_W-1:0] x_i,
  input  logic signed [DATA_W-1:0] y_i,
  input  logic signed [ANG_W-1:0]  z_i,
  output logic                     vld_o,
  output logic signed [DATA_W-1:0] x_o,
  output logic signed [DATA_W-1:0] y_o,
  output logic signed [ANG_W-1:0]  z_o
);

  logic                     vld_r;
  logic signed [DATA_W-1:0] x_r, x_nxt;
  logic signed [DATA_W-1:0] y_r, y_nxt;
  logic signed [ANG_W-1:0]  z_r, z_nxt;
  logic signed [DATA_W-1:0] dx;
  logic signed [DATA_W-1:0] dy;
  logic signed [ANG_W-1:0]  step;

  // Vectoring micro-rotation: drive y toward zero, accumulate the angle.
  always_comb begin
    dx    = y_i >>> idx_i;
    dy    = x_i >>> idx_i;
    step  = ANG_W'(ATAN_TAB[idx_i]);
    x_nxt = x_i;
    y_nxt = y_i;
    z_nxt = z_i;
    if (y_i[DATA_W-1]) begin
      x_nxt = x_i - dx;
      y_nxt = y_i + dy;
      z_nxt = z_i - step;
    end else if (y_i != '0) begin
      x_nxt = x_i + dx;
      y_nxt = y_i - dy;
      z_nxt = z_i + step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
  end

  assign vld_o = vld_r;
  assign x_o   = x_r;
  assign y_o   = y_r;
  assign z_o   = z_r;

endmodule

// File: sv/tah_atan2_pipe.sv
`include "tilt_and_heading_angles_unit_defines.svh"

module tah_atan2_pipe
  import tah_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     vld_i,
  input  logic signed [DATA_W-1:0] x_i,
  input  logic signed [DATA_W-1:0] y_i,
  output logic                     vld_o,
  output logic signed [ANG_W-1:0]  z_o
);

  logic                     prep_vld_r;
  logic signed [DATA_W-1:0] prep_x_r;
  logic signed [DATA_W-1:0] prep_y_r;
  logic [MAG_W-1:0]         prep_m_r, prep_m_nxt;
  logic [DATA_W-1:0]        abs_x;
  logic [DATA_W-1:0]        abs_y;

  logic                     nvld [NORM_STAGES+1];
  logic signed [DATA_W-1:0] nx   [NORM_STAGES+1];
  logic signed [DATA_W-1:0] ny   [NORM_STAGES+1];
  logic [MAG_W-1:0]         nm   [NORM_STAGES+1];

  logic                     fold_vld_r;
  logic signed [DATA_W-1:0] fold_x_r, fold_x_nxt;
  logic signed [DATA_W-1:0] fold_y_r, fold_y_nxt;
  logic signed [ANG_W-1:0]  fold_z_r, fold_z_nxt;

  logic                     rvld [ROT_STEPS+1];
  logic signed [DATA_W-1:0] rx   [ROT_STEPS+1];
  logic signed [DATA_W-1:0] ry   [ROT_STEPS+1];
  logic signed [ANG_W-1:0]  rz   [ROT_STEPS+1];

  always_comb begin
    abs_x      = x_i[DATA_W-1] ? DATA_W'(-x_i) : DATA_W'(x_i);
    abs_y      = y_i[DATA_W-1] ? DATA_W'(-y_i) : DATA_W'(y_i);
    prep_m_nxt = (abs_x > abs_y) ? abs_x[MAG_W-1:0] : abs_y[MAG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prep_vld_r <= 1'b0;
    end else begin
      prep_vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    prep_x_r <= x_i;
    prep_y_r <= y_i;
    prep_m_r <= prep_m_nxt;
  end

  assign nvld[0] = prep_vld_r;
  assign nx[0]   = prep_x_r;
  assign ny[0]   = prep_y_r;
  assign nm[0]   = prep_m_r;

  // Binary search for the scaling: shifts of 32, 16, ..., 1 that keep the
  // magnitude below 2^NORM_EXP, then one more doubling to reach it.
  // A zero vector passes through unchanged.
  for (genvar j = 0; j < NORM_STAGES; j++) begin : g_norm
    localparam int SH = (j < NORM_STAGES - 1) ? (2 ** (NORM_STAGES - 2 - j)) : 1;
    localparam int EX = (j < NORM_STAGES - 1) ? (NORM_EXP - SH) : NORM_EXP;
    tah_norm_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .sh_i  (SHIFT_W'(SH)),
      .exp_i (SHIFT_W'(EX)),
      .vld_i (nvld[j]),
      .x_i   (nx[j]),
      .y_i   (ny[j]),
      .m_i   (nm[j]),
      .vld_o (nvld[j+1]),
      .x_o   (nx[j+1]),
      .y_o   (ny[j+1]),
      .m_o   (nm[j+1])
    );
  end

  // Left half plane: mirror the vector and start from +-180 degrees.
  always_comb begin
    fold_x_nxt = nx[NORM_STAGES];
    fold_y_nxt = ny[NORM_STAGES];
    fold_z_nxt = '0;
    if (nx[NORM_STAGES][DATA_W-1]) begin
      fold_x_nxt = -nx[NORM_STAGES];
      fold_y_nxt = -ny[NORM_STAGES];
      fold_z_nxt = ny[NORM_STAGES][DATA_W-1] ? -HALF_TURN_Z : HALF_TURN_Z;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fold_vld_r <= 1'b0;
    end else begin
      fold_vld_r <= nvld[NORM_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    fold_x_r <= fold_x_nxt;
    fold_y_r <= fold_y_nxt;
    fold_z_r <= fold_z_nxt;
  end

  assign rvld[0] = fold_vld_r;
  assign rx[0]   = fold_x_r;
  assign ry[0]   = fold_y_r;
  assign rz[0]   = fold_z_r;

  for (genvar j = 0; j < ROT_STEPS; j++) begin : g_rot
    tah_rot_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .idx_i (ROT_IDX_W'(j)),
      .vld_i (rvld[j]),
      .x_i   (rx[j]),
      .y_i   (ry[j]),
      .z_i   (rz[j]),
      .vld_o (rvld[j+1]),
      .x_o   (rx[j+1]),
      .y_o   (ry[j+1]),
      .z_o   (rz[j+1])
    );
  end

  assign vld_o = rvld[ROT_STEPS];
  assign z_o   = rz[ROT_STEPS];

  `TAH_ASSERT_NOW(a_norm_reached, nvld[NORM_STAGES], nm[NORM_STAGES][NORM_EXP] || (nm[NORM_STAGES] == '0), "scaling left a nonzero magnitude below the target")
  `TAH_ASSERT_NOW(a_fold_right_half, fold_vld_r, !fold_x_r[DATA_W-1], "vector still in the left half plane after folding")
  `TAH_ASSERT_NEXT(a_fold_start_pos, nx[NORM_STAGES][DATA_W-1] && !ny[NORM_STAGES][DATA_W-1], fold_z_r == HALF_TURN_Z, "upper left quadrant did not start at +180 degrees")

endmodule

// File: sv/tilt_and_heading_angles_unit.sv
// Pitch and heading from one accelerometer / magnetometer sample set.
// Input: assert start with the five raw axis counts on in_*; a word is taken
// at every rising edge where start is high and busy is low. busy stays low,
// so a new word can be given in every cycle.
// Output: out_strobe is high for one cycle with out_pitch_angle and
// out_heading_angle, both in 1/128 degree. The receiver cannot stall; each
// result must be taken in the cycle it is shown.
// From accept to strobe a word passes two front stages (squares, sum),
// 24 square-root cells, one operand stage, 7 scaling cells, one half-plane
// fold stage, 16 CORDIC micro-rotation cells and the output register.
// Throughput is one word per cycle, and results come out in the order the
// words went in.
// Pitch is atan2(-x, sqrt(y^2 + z^2)) and heading is atan2(my, mx); a zero
// vector gives an angle of 0.
// Reset (synchronous, active low) clears all valid flags, so words in flight
// are dropped and no strobe follows until new words are accepted.
`include "tilt_and_heading_angles_unit_defines.svh"

module tilt_and_heading_angles_unit
  import tah_pkg::*;
(
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic signed [SAMPLE_WIDTH-1:0] in_accel_x,
  input  logic signed [SAMPLE_WIDTH-1:0] in_accel_y,
  input  logic signed [SAMPLE_WIDTH-1:0] in_accel_z,
  input  logic signed [SAMPLE_WIDTH-1:0] in_mag_x,
  input  logic signed [SAMPLE_WIDTH-1:0] in_mag_y,
  output logic                           out_strobe,
  output logic signed [PITCH_W-1:0]      out_pitch_angle,
  output logic signed [HEAD_W-1:0]       out_heading_angle
);

  logic                     a_vld_r;
  logic signed [SUM_W-1:0]  a_sq_y_r;
  logic signed [SUM_W-1:0]  a_sq_z_r;
  tah_side_t                a_side_r;

  logic                     b_vld_r;
  logic [SUM_W-1:0]         b_sum_r, b_sum_nxt;
  tah_side_t                b_side_r;

  logic                     s_vld  [SQ_R_W+1];
  logic [SQ_N_W-1:0]        s_n    [SQ_R_W+1];
  logic [SQ_REM_W-1:0]      s_rem  [SQ_R_W+1];
  logic [SQ_R_W-1:0]        s_q    [SQ_R_W+1];
  tah_side_t                s_side [SQ_R_W+1];

  tah_side_t                sq_side;
  logic signed [DATA_W-1:0] ax_ext;
  logic signed [DATA_W-1:0] p_x;
  logic signed [DATA_W-1:0] p_y;
  logic signed [DATA_W-1:0] h_x;
  logic signed [DATA_W-1:0] h_y;

  logic                     p_vld;
  logic                     h_vld;
  logic signed [ANG_W-1:0]  p_z;
  logic signed [ANG_W-1:0]  h_z;

  logic                     out_strobe_r;
  logic signed [PITCH_W-1:0] pitch_r, pitch_nxt;
  logic signed [HEAD_W-1:0] heading_r, heading_nxt;
  logic signed [HEAD_W-1:0] pitch_wide;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else begin
      a_vld_r <= start;
      b_vld_r <= a_vld_r;
    end
  end

  assign b_sum_nxt = SUM_W'($unsigned(a_sq_y_r) + $unsigned(a_sq_z_r));

  always_ff @(posedge clk) begin
    a_sq_y_r <= in_accel_y * in_accel_y;
    a_sq_z_r <= in_accel_z * in_accel_z;
    a_side_r <= '{ax: in_accel_x, mx: in_mag_x, my: in_mag_y};
    b_sum_r  <= b_sum_nxt;
    b_side_r <= a_side_r;
  end

  // The radicand carries 2*MAG_GUARD zero bits so the root has MAG_GUARD
  // fraction bits.
  assign s_vld[0]  = b_vld_r;
  assign s_n[0]    = {b_sum_r, (2 * MAG_GUARD)'(0)};
  assign s_rem[0]  = '0;
  assign s_q[0]    = '0;
  assign s_side[0] = b_side_r;

  for (genvar j = 0; j < SQ_R_W; j++) begin : g_sqrt
    tah_sqrt_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .vld_i  (s_vld[j]),
      .n_i    (s_n[j]),
      .rem_i  (s_rem[j]),
      .q_i    (s_q[j]),
      .side_i (s_side[j]),
      .vld_o  (s_vld[j+1]),
      .n_o    (s_n[j+1]),
      .rem_o  (s_rem[j+1]),
      .q_o    (s_q[j+1]),
      .side_o (s_side[j+1])
    );
  end

  always_comb begin
    sq_side = s_side[SQ_R_W];
    ax_ext  = DATA_W'(sq_side.ax);
    p_x     = DATA_W'(s_q[SQ_R_W]);
    p_y     = -(ax_ext <<< MAG_GUARD);
    h_x     = DATA_W'(sq_side.mx);
    h_y     = DATA_W'(sq_side.my);
  end

  tah_atan2_pipe u_pitch (
    .clk   (clk),
    .rst_n (rst_n),
    .vld_i (s_vld[SQ_R_W]),
    .x_i   (p_x),
    .y_i   (p_y),
    .vld_o (p_vld),
    .z_o   (p_z)
  );

  tah_atan2_pipe u_heading (
    .clk   (clk),
    .rst_n (rst_n),
    .vld_i (s_vld[SQ_R_W]),
    .x_i   (h_x),
    .y_i   (h_y),
    .vld_o (h_vld),
    .z_o   (h_z)
  );

  always_comb begin
    pitch_wide  = round_sat(p_z, PITCH_MAX);
    pitch_nxt   = pitch_wide[PITCH_W-1:0];
    heading_nxt = round_sat(h_z, HEADING_MAX);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= p_vld;
    end
  end

  always_ff @(posedge clk) begin
    pitch_r   <= pitch_nxt;
    heading_r <= heading_nxt;
  end

  assign out_strobe        = out_strobe_r;
  assign out_pitch_angle   = pitch_r;
  assign out_heading_angle = heading_r;

  `TAH_ASSERT_NOW(a_lanes_aligned, p_vld || h_vld, p_vld && h_vld, "pitch and heading lanes out of step")
  `TAH_ASSERT_NOW(a_pitch_range, out_strobe, (out_pitch_angle <= PITCH_W'(PITCH_MAX)) && (out_pitch_angle >= -PITCH_W'(PITCH_MAX)), "pitch outside +-90 degrees")
  `TAH_ASSERT_NOW(a_heading_range, out_strobe, (out_heading_angle <= HEAD_W'(HEADING_MAX)) && (out_heading_angle >= -HEAD_W'(HEADING_MAX)), "heading outside +-180 degrees")

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import tah_pkg::*;

  localparam int    RANDOM_WORDS   = 1800;
  localparam int    CYCLE_LIMIT    = 500000;
  localparam int    DRAIN_CYCLES   = 60;
  localparam int    ROTATION_COUNT = ROTATION_STEPS;
  localparam longint SCALE_FLOOR   = 64'sd1 << 40;
  localparam longint HALF_TURN_Z   = 64'sd180 * 64'sd32768;

  typedef struct packed {
    logic signed [PITCH_W-1:0] pitch;
    logic signed [HEAD_W-1:0]  heading;
  } angle_pair_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] ax;
    logic signed [SAMPLE_WIDTH-1:0] ay;
    logic signed [SAMPLE_WIDTH-1:0] az;
    logic signed [SAMPLE_WIDTH-1:0] mx;
    logic signed [SAMPLE_WIDTH-1:0] my;
    logic                           typed;
    angle_pair_t                    angles;
  } sample_row_t;

  logic                           clk;
  logic                           rst_n;
  logic                           start;
  logic                           busy;
  logic signed [SAMPLE_WIDTH-1:0] in_accel_x;
  logic signed [SAMPLE_WIDTH-1:0] in_accel_y;
  logic signed [SAMPLE_WIDTH-1:0] in_accel_z;
  logic signed [SAMPLE_WIDTH-1:0] in_mag_x;
  logic signed [SAMPLE_WIDTH-1:0] in_mag_y;
  logic                           out_strobe;
  logic signed [PITCH_W-1:0]      out_pitch_angle;
  logic signed [HEAD_W-1:0]       out_heading_angle;

  angle_pair_t pending_angles[$];
  angle_pair_t next_angles;
  sample_row_t directed_rows [20];
  int          words_sent;
  int          pairs_checked;
  int          mismatches;
  int          cycle_count;

  tilt_and_heading_angles_unit u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_accel_x        (in_accel_x),
    .in_accel_y        (in_accel_y),
    .in_accel_z        (in_accel_z),
    .in_mag_x          (in_mag_x),
    .in_mag_y          (in_mag_y),
    .out_strobe        (out_strobe),
    .out_pitch_angle   (out_pitch_angle),
    .out_heading_angle (out_heading_angle)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Arctangent of 2^-i in degrees with 15 fraction bits.
  function automatic longint atan_step(int i);
    case (i)
      0: return 1474560;   1: return 870484;   2: return 459940;   3: return 233473;
      4: return 117189;    5: return 58653;    6: return 29333;    7: return 14667;
      8: return 7334;      9: return 3667;     10: return 1833;    11: return 917;
      12: return 458;      13: return 229;     14: return 115;     15: return 57;
      16: return 29;       17: return 14;      18: return 7;       19: return 4;
      20: return 2;        21: return 1;
      default: return 0;
    endcase
  endfunction

  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b   = 64'h4000_0000_0000_0000;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n   = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // CORDIC vectoring; the angle of (xv, yv) in 1/32768 degree.
  function automatic longint vector_angle(longint yv, longint xv);
    longint z;
    longint m;
    longint dx;
    longint dy;
    z = 0;
    if (xv == 0 && yv == 0) return 0;
    m = (xv < 0) ? -xv : xv;
    if (((yv < 0) ? -yv : yv) > m) m = (yv < 0) ? -yv : yv;
    while (m < SCALE_FLOOR) begin
      xv = xv * 2;
      yv = yv * 2;
      m  = m * 2;
    end
    // Fold the left half plane over and start from a half turn.
    if (xv < 0) begin
      z  = (yv >= 0) ? HALF_TURN_Z : -HALF_TURN_Z;
      xv = -xv;
      yv = -yv;
    end
    for (int i = 0; i < ROTATION_COUNT && i < 24; i++) begin
      dx = yv >>> i;
      dy = xv >>> i;
      if (yv > 0) begin
        xv = xv + dx;
        yv = yv - dy;
        z  = z + atan_step(i);
      end else if (yv < 0) begin
        xv = xv - dx;
        yv = yv + dy;
        z  = z - atan_step(i);
      end
    end
    return z;
  endfunction

  function automatic longint to_units(longint z, longint lim);
    longint r;
    r = (z + 128) >>> 8;
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  function automatic angle_pair_t predict_angles(sample_row_t s);
    angle_pair_t    a;
    longint         sq_sum;
    longint unsigned mag;
    longint         neg_x;
    sq_sum  = longint'(s.ay) * longint'(s.ay) + longint'(s.az) * longint'(s.az);
    mag     = root_floor(longint'(unsigned'(sq_sum)) << 16);
    neg_x   = -longint'(s.ax) * 256;
    a.pitch = PITCH_W'(to_units(vector_angle(neg_x, longint'(mag)), PITCH_MAX));
    a.heading = HEAD_W'(to_units(vector_angle(longint'(s.my), longint'(s.mx)),
                                 HEADING_MAX));
    return a;
  endfunction

  function automatic sample_row_t mk_row(int ax, int ay, int az, int mx, int my,
                                         bit typed = 1'b0, int p = 0, int h = 0);
    sample_row_t r;
    r.ax             = SAMPLE_WIDTH'(ax);
    r.ay             = SAMPLE_WIDTH'(ay);
    r.az             = SAMPLE_WIDTH'(az);
    r.mx             = SAMPLE_WIDTH'(mx);
    r.my             = SAMPLE_WIDTH'(my);
    r.typed          = typed;
    r.angles.pitch   = PITCH_W'(p);
    r.angles.heading = HEAD_W'(h);
    return r;
  endfunction

  function automatic logic signed [SAMPLE_WIDTH-1:0] rand_axis(int mode);
    logic signed [SAMPLE_WIDTH-1:0] v;
    case (mode)
      0: v = SAMPLE_WIDTH'($urandom);
      1: v = SAMPLE_WIDTH'($urandom_range(0, 16)) - SAMPLE_WIDTH'(8);
      2: begin
        case ($urandom_range(0, 5))
          0: v = 16'sh8000;
          1: v = 16'sh8001;
          2: v = 16'shFFFF;
          3: v = 16'sh0000;
          4: v = 16'sh0001;
          default: v = 16'sh7FFF;
        endcase
      end
      default: v = $signed(SAMPLE_WIDTH'($urandom)) >>> $urandom_range(0, 15);
    endcase
    return v;
  endfunction

  function automatic sample_row_t rand_sample();
    sample_row_t s;
    int          kind;
    int          mode;
    kind = $urandom_range(0, 9);
    mode = (kind < 4) ? 0 : (kind - 3);
    s    = '0;
    if (kind == 7 || kind == 8 || kind == 9) begin
      s.ax = rand_axis($urandom_range(0, 3));
      s.ay = rand_axis($urandom_range(0, 3));
      s.az = rand_axis($urandom_range(0, 3));
      s.mx = rand_axis($urandom_range(0, 3));
      s.my = rand_axis($urandom_range(0, 3));
    end else begin
      s.ax = rand_axis(mode);
      s.ay = rand_axis(mode);
      s.az = rand_axis(mode);
      s.mx = rand_axis(mode);
      s.my = rand_axis(mode);
    end
    // Vectors on an axis: the rotation sees y equal to zero, or x equal to zero.
    if (kind == 8) begin
      if ($urandom_range(0, 1)) s.my = '0;
      else s.mx = '0;
      if ($urandom_range(0, 1)) begin
        s.ay = '0;
        s.az = '0;
      end else begin
        s.ax = '0;
      end
    end
    if (kind == 9) begin
      if ($urandom_range(0, 1)) s.ax = '0;
      if ($urandom_range(0, 1)) s.ay = '0;
      if ($urandom_range(0, 1)) s.az = '0;
      if ($urandom_range(0, 1)) s.mx = '0;
      if ($urandom_range(0, 1)) s.my = '0;
    end
    return s;
  endfunction

  task automatic idle_cycles(int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  task automatic pace(bit allow);
    int r;
    r = $urandom_range(0, 99);
    if (allow && r < 12) idle_cycles($urandom_range(1, 2));
  endtask

  task automatic send_word(sample_row_t s);
    @(negedge clk);
    next_angles = s.typed ? s.angles : predict_angles(s);
    in_accel_x <= s.ax;
    in_accel_y <= s.ay;
    in_accel_z <= s.az;
    in_mag_x   <= s.mx;
    in_mag_y   <= s.my;
    start      <= 1'b1;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    angle_pair_t want;
    if (rst_n === 1'b1 && out_strobe === 1'b1) begin
      if (pending_angles.size() == 0) begin
        $error("out_strobe with no angle pair pending");
        mismatches++;
      end else begin
        want = pending_angles.pop_front();
        pairs_checked++;
        if (out_pitch_angle !== want.pitch) begin
          $error("pitch_angle: expected %0d, got %0d", want.pitch, out_pitch_angle);
          mismatches++;
        end
        if (out_heading_angle !== want.heading) begin
          $error("heading_angle: expected %0d, got %0d", want.heading, out_heading_angle);
          mismatches++;
        end
      end
    end
    if (rst_n === 1'b1 && start === 1'b1 && busy === 1'b0) begin
      pending_angles.push_back(next_angles);
      words_sent++;
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    bit calm;
    rst_n         = 1'b0;
    start         = 1'b0;
    in_accel_x    = '0;
    in_accel_y    = '0;
    in_accel_z    = '0;
    in_mag_x      = '0;
    in_mag_y      = '0;
    next_angles   = '0;
    words_sent    = 0;
    pairs_checked = 0;
    mismatches    = 0;

    // Zero vectors and vectors on the x axis (y = 0), in either half plane,
    // have answers that need no arithmetic; the rest go through the predictor.
    directed_rows[0]  = mk_row(0, 0, 0, 0, 0, 1'b1, 0, 0);
    directed_rows[1]  = mk_row(0, 100, 0, 1, 0, 1'b1, 0, 0);
    directed_rows[2]  = mk_row(0, 0, 0, -1, 0, 1'b1, 0, 23040);
    directed_rows[3]  = mk_row(0, 0, -32768, -32768, 0, 1'b1, 0, 23040);
    directed_rows[4]  = mk_row(0, -32768, -32768, 32767, 0, 1'b1, 0, 0);
    directed_rows[5]  = mk_row(-32768, 0, 0, 0, 32767);
    directed_rows[6]  = mk_row(32767, 0, 0, 0, -32768);
    directed_rows[7]  = mk_row(-32768, 1, 0, -32768, -1);
    directed_rows[8]  = mk_row(32767, 0, 1, -32768, 1);
    directed_rows[9]  = mk_row(1, 32767, 32767, 32767, 32767);
    directed_rows[10] = mk_row(-1, -32768, -32768, -32768, -32768);
    directed_rows[11] = mk_row(-32768, -32768, -32768, 32767, -32768);
    directed_rows[12] = mk_row(32767, 32767, -32768, -32768, 32767);
    directed_rows[13] = mk_row(1, 0, 0, 1, 1);
    directed_rows[14] = mk_row(-1, -1, 1, -1, -1);
    directed_rows[15] = mk_row(12345, -2345, 30000, -7000, 15000);
    directed_rows[16] = mk_row(-20000, 5, -3, 3, -20000);
    directed_rows[17] = mk_row(0, 0, 0, 0, 1);
    directed_rows[18] = mk_row(0, 0, 0, 0, -1);
    directed_rows[19] = mk_row('h5555, 'hAAAA, 'h5555, 'hAAAA, 'h5555);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      pace(1'b1);
      send_word(directed_rows[i]);
    end

    for (int k = 0; k < RANDOM_WORDS; k++) begin
      calm = (k >= 600 && k < 1000);
      // Let the pipeline run completely dry once before carrying on.
      if (k == 1200) begin
        idle_cycles(1);
        while (pending_angles.size() != 0) @(posedge clk);
      end
      pace(!calm);
      send_word(rand_sample());
    end

    idle_cycles(1);
    while (pending_angles.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Summary: %0d sample sets sent (%0d from the directed table), %0d angle pairs",
             words_sent, $size(directed_rows), pairs_checked);
    $display("Summary: compared field by field, %0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
